// ----- rtl/core/proth_primality_prover_macros.svh -----
// Assertion macros shared by the prover RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef PROTH_PRIMALITY_PROVER_MACROS_SVH
`define PROTH_PRIMALITY_PROVER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pp_pkg.sv -----
// Shared types and constants for the Proth prover.
// No dependencies.
`timescale 1ns / 1ps
package pp_pkg;
    localparam logic [1:0] ST_PROVEN      = 2'd0;
    localparam logic [1:0] ST_NOT_PROVEN  = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic OP_PROVE  = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    // APB register address (byte address 0)
    localparam logic REG_MAX_WITNESS = 1'b0;

    localparam logic [63:0] MAX_WITNESS_RESET = 64'd1024;

    typedef enum logic [2:0] {
        DP_NONE  = 3'b001,
        DP_LOAD  = 3'b010,   // latch operands, form value
        DP_MUL   = 3'b100    // start one modular multiplication
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sq;        // 1: base := base*base, 0: r := r*base
        logic   pow_init;  // r := 1, base := w, e := (N-1)/2
        logic   next_w;    // w := w + 1
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic e_zero;      // exponent exhausted
        logic e_lsb;
        logic e_last;      // exponent will be zero after shift
        logic res_hit;     // r == N-1
        logic w_at_limit;
        logic form_ok;
        logic claim_ok;
    } t_sts;
endpackage

// ----- rtl/core/pp_datapath.sv -----
// Datapath: operand registers, bit-serial modular multiplier, exponent shifter.
// Depends on pp_pkg.
`timescale 1ns / 1ps
module pp_datapath #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pp_pkg::t_cmd         i_cmd,
    input  logic [31:0]          i_multiplier_k,
    input  logic [5:0]           i_exponent_n,
    input  logic [63:0]          i_claimed_value,
    input  logic [63:0]          i_claimed_witness,
    input  logic [63:0]          i_claimed_residue,
    input  logic                 i_opcode,
    input  logic [63:0]          i_max_witness,
    output pp_pkg::t_sts         o_sts,
    output logic [WORD_BITS-1:0] o_n,
    output logic [WORD_BITS-1:0] o_w,
    output logic [WORD_BITS-1:0] o_r
);
    import pp_pkg::*;

    localparam int WB = WORD_BITS;
    localparam int CW = $clog2(WB + 1);

    logic [WB-1:0] r_n, r_w, r_lim, r_r, r_base, r_e;
    logic [WB-1:0] r_ma, r_mb, r_acc;
    logic          r_mbusy, r_msq;
    logic          r_form_ok, r_claim_ok;
    logic [CW-1:0] r_mcnt;

    // Form check on the incoming item
    logic [63:0]   k64, nval, lim_eff, nm1_64;
    logic          form_ok, claim_ok;
    logic [127:0]  shk;
    always_comb begin
        k64     = {32'd0, i_multiplier_k};
        shk     = {64'd0, k64} << i_exponent_n;
        form_ok = i_multiplier_k[0] && (i_exponent_n != 6'd0)
                  && (32'(i_exponent_n) < WB)
                  && (shk[127:64] == 64'd0) && ((k64 >> i_exponent_n) == 64'd0);
        nval    = shk[63:0] + 64'd1;
        if (WB < 64 && (nval >> WB) != 64'd0) form_ok = 1'b0;
        nm1_64  = nval - 64'd1;
        lim_eff = (i_max_witness < 64'd2) ? 64'd2 : i_max_witness;
        if (lim_eff > nm1_64) lim_eff = nm1_64;
        claim_ok = (i_claimed_witness >= 64'd2) && (i_claimed_value == nval)
                   && (i_claimed_witness < nval) && (i_claimed_residue == nm1_64);
    end

    // add_mod on reduced operands
    function automatic logic [WB-1:0] addm(input logic [WB-1:0] a, input logic [WB-1:0] b,
                                           input logic [WB-1:0] m);
        logic [WB-1:0] room;
        room = m - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    logic [WB-1:0] nm1;
    assign nm1 = r_n - WB'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else begin
            if (i_cmd.op == DP_LOAD) begin
                r_n        <= nval[WB-1:0];
                r_lim      <= lim_eff[WB-1:0];
                r_form_ok  <= form_ok;
                r_claim_ok <= claim_ok;
                r_w        <= (i_opcode == OP_VERIFY) ? i_claimed_witness[WB-1:0] : WB'(2);
            end
            if (i_cmd.next_w) r_w <= r_w + WB'(1);
            if (i_cmd.pow_init) begin
                r_r    <= WB'(1);
                r_base <= r_w;        // w < N so already reduced
                r_e    <= nm1 >> 1;
            end
            if (i_cmd.op == DP_MUL) begin
                r_mbusy <= 1'b1;
                r_msq   <= i_cmd.sq;
                r_ma    <= r_base;
                r_mb    <= i_cmd.sq ? r_base : r_r;
                r_acc   <= '0;
                r_mcnt  <= CW'(WB);
                if (i_cmd.sq) r_e <= r_e >> 1;   // exponent steps with each square
            end else if (r_mbusy) begin
                // one bit of the multiplier a cycle, LSB first
                if (r_mb[0]) r_acc <= addm(r_acc, r_ma, r_n);
                r_ma   <= addm(r_ma, r_ma, r_n);
                r_mb   <= r_mb >> 1;
                r_mcnt <= r_mcnt - CW'(1);
                if (r_mcnt == CW'(1) || r_mb[WB-1:1] == '0) begin
                    r_mbusy <= 1'b0;
                    if (r_msq) r_base <= r_mb[0] ? addm(r_acc, r_ma, r_n) : r_acc;
                    else       r_r    <= r_mb[0] ? addm(r_acc, r_ma, r_n) : r_acc;
                end
            end
        end
    end

    assign o_sts.mul_busy   = r_mbusy;
    assign o_sts.e_zero     = (r_e == '0);
    assign o_sts.e_lsb      = r_e[0];
    assign o_sts.e_last     = (r_e[WB-1:1] == '0);
    assign o_sts.res_hit    = (r_r == nm1);
    assign o_sts.w_at_limit = (r_w >= r_lim);
    assign o_sts.form_ok    = r_form_ok;
    assign o_sts.claim_ok   = r_claim_ok;
    assign o_n = r_n;
    assign o_w = r_w;
    assign o_r = r_r;
endmodule

// ----- rtl/core/pp_ctrl.sv -----
// Controller: sequences witness search and power evaluation.
// Depends on pp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "proth_primality_prover_macros.svh"
module pp_ctrl #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_opcode,
    input  pp_pkg::t_sts         i_sts,
    input  logic [WORD_BITS-1:0] i_n,
    input  logic [WORD_BITS-1:0] i_w,
    input  logic [WORD_BITS-1:0] i_r,
    output pp_pkg::t_cmd         o_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [63:0]          o_candidate_value,
    output logic [63:0]          o_found_witness,
    output logic [63:0]          o_found_residue,
    output logic [63:0]          o_bases_tried
);
    import pp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_INIT  = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_op, r_sq, n_sq;
    logic [63:0] r_tried, n_tried;
    logic [1:0]  r_status, n_status;
    logic [63:0] r_cand, r_fw, r_fr, n_cand, n_fw, n_fr;
    logic        r_done, n_done;

    always_comb begin
        n_state  = r_state;
        n_sq     = r_sq;
        n_tried  = r_tried;
        n_status = r_status;
        n_cand   = r_cand;
        n_fw     = r_fw;
        n_fr     = r_fr;
        n_done   = 1'b0;
        o_cmd    = '{op: DP_NONE, sq: 1'b0, pow_init: 1'b0, next_w: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_tried = '0; n_fw = '0; n_fr = '0;
                n_cand  = 64'(i_n);
                n_status = ST_NOT_PROVEN;
                if (!i_sts.form_ok) begin
                    n_cand   = '0;
                    n_status = (r_op == OP_PROVE) ? ST_UNSUPPORTED : ST_NOT_PROVEN;
                    n_state  = S_DONE;
                end else if (r_op == OP_VERIFY && !i_sts.claim_ok) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.pow_init = 1'b1;
                n_tried = r_tried + 64'd1;
                n_state = S_STEP;
            end
            S_STEP: begin
                // r*base when the exponent bit is set, then square if more bits remain
                if (!r_sq) begin
                    if (i_sts.e_zero) begin
                        n_state = S_EVAL;
                    end else if (i_sts.e_lsb) begin
                        o_cmd.op = DP_MUL; o_cmd.sq = 1'b0;
                        n_sq = 1'b1; n_state = S_WAIT;
                    end else begin
                        n_sq = 1'b1;
                    end
                end else begin
                    // the square also shifts the exponent; none after the top bit
                    n_sq = 1'b0;
                    if (i_sts.e_last) n_state = S_EVAL;
                    else begin
                        o_cmd.op = DP_MUL; o_cmd.sq = 1'b1; n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (!i_sts.mul_busy) n_state = S_STEP;
            end
            S_EVAL: begin
                if (i_sts.res_hit) begin
                    n_status = ST_PROVEN;
                    n_fw = 64'(i_w); n_fr = 64'(i_r);
                    n_state = S_DONE;
                end else if (r_op == OP_VERIFY || i_sts.w_at_limit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_w = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_sq    <= n_sq;
        end
        if (r_state == S_IDLE && i_start) r_op <= i_opcode;
        r_tried  <= n_tried;
        r_status <= n_status;
        r_cand   <= n_cand;
        r_fw     <= n_fw;
        r_fr     <= n_fr;
    end

    assign o_busy            = (r_state != S_IDLE) || r_done;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_candidate_value = r_cand;
    assign o_found_witness   = r_fw;
    assign o_found_residue   = r_fr;
    assign o_bases_tried     = r_tried;

    `PPP_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held two cycles")
    `PPP_ASSERT_IMP(a_proven_hit, i_clk, i_rst_n, r_done && r_status == ST_PROVEN,
                    r_fw != 64'd0, "proven without witness")
    `PPP_ASSERT_IMP(a_wait_mul, i_clk, i_rst_n, r_state == S_EVAL, !i_sts.mul_busy,
                    "evaluation while multiplier busy")
endmodule

// ----- rtl/core/proth_primality_prover.sv -----
// Proth prover: one request at a time; busy is high from the accepting edge through the
// one-cycle result strobe, so the next request is taken only once the strobe has dropped.
// Each witness costs a power evaluation of up to 2*WORD_BITS-3 bit-serial modular multiplies;
// prove mode repeats that for each base tried. The receiver cannot stall.
// Sync active-low reset returns to idle and max_witness to 1024.
`timescale 1ns / 1ps
module proth_primality_prover #(
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_multiplier_k,
    input  logic [5:0]  i_exponent_n,
    input  logic [63:0] i_claimed_value,
    input  logic [63:0] i_claimed_witness,
    input  logic [63:0] i_claimed_residue,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_candidate_value,
    output logic [63:0] o_found_witness,
    output logic [63:0] o_found_residue,
    output logic [63:0] o_bases_tried
);
    import pp_pkg::*;

    logic [63:0] r_max_witness;
    t_cmd        cmd;
    t_sts        sts;
    logic [WORD_BITS-1:0] dp_n, dp_w, dp_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_witness <= MAX_WITNESS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_MAX_WITNESS) begin
            r_max_witness <= pwdata;
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_WITNESS) ? r_max_witness : 64'd0;

    pp_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_multiplier_k, .i_exponent_n, .i_claimed_value,
        .i_claimed_witness, .i_claimed_residue, .i_opcode,
        .i_max_witness(r_max_witness),
        .o_sts(sts), .o_n(dp_n), .o_w(dp_w), .o_r(dp_r)
    );

    pp_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start && !busy), .i_opcode,
        .i_sts(sts), .i_n(dp_n), .i_w(dp_w), .i_r(dp_r),
        .o_cmd(cmd), .o_busy(busy), .o_done(o_valid),
        .o_status, .o_candidate_value, .o_found_witness,
        .o_found_residue, .o_bases_tried
    );
endmodule
